### rtl/llfp_pkg.sv
// Shared types and codes for the linked list with free pool.
// Used by the top level and by its port checker; depends on nothing.
package llfp_pkg;

  typedef logic [2:0] kind_t;
  typedef logic [1:0] status_t;

  localparam kind_t KIND_PUSH_BACK  = 3'd0;
  localparam kind_t KIND_PUSH_FRONT = 3'd1;
  localparam kind_t KIND_INSERT     = 3'd2;
  localparam kind_t KIND_DELETE     = 3'd3;
  localparam kind_t KIND_FIND       = 3'd4;
  localparam kind_t KIND_CLEAR      = 3'd5;

  localparam status_t ST_DONE = 2'd0;
  localparam status_t ST_MISS = 2'd1;
  localparam status_t ST_FULL = 2'd2;

  localparam int IDX_OUT_W   = 8;
  localparam int COUNT_OUT_W = 9;

endpackage

### rtl/llfp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Holds the node arrays of the list; depends on nothing.
module llfp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/linked_list_with_free_pool_unit.sv
// Doubly linked list of data words in a fixed pool of NODES nodes, with a free chain
// taken from its head and returned to its tail. One operation is in flight at a time
// and in_stall is high until it has finished. Push back and push front end early when
// the pool is full. Insert, delete and find walk the list from its head through the
// data and next-link RAM read ports at one node per cycle, with the single equality
// comparator checking each node, followed by link updates in S_TAKE, S_LINK1 and
// S_LINK2 for insert or in S_DEL, S_FREE and S_FREE2 for delete. Clear rewrites the
// link RAMs one node per cycle. After reset the same clearing pass runs before the
// first item is taken. A finished result sits in the output register, so the next
// item can be taken while it waits.
// Depends on llfp_pkg and llfp_ram.
module linked_list_with_free_pool_unit
  import llfp_pkg::*;
#(
  parameter int NODES      = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_kind,
  input  logic [31:0] in_value,
  input  logic [31:0] in_anchor,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [7:0]  out_node_index,
  output logic [8:0]  out_used_count
);

  localparam int IW = $clog2(NODES);
  localparam int PW = IW + 1;
  localparam logic [PW-1:0] NIL      = PW'(NODES);
  localparam logic [IW-1:0] LAST_IDX = IW'(NODES - 1);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DISP, S_WALK, S_TAKE, S_LINK1, S_LINK2,
    S_DEL, S_FREE, S_FREE2, S_DONE
  } state_t;

  state_t                state_r, state_nxt;
  logic                  init_r, init_nxt;
  logic [IW-1:0]         clr_r, clr_nxt;
  kind_t                 kind_r, kind_nxt;
  logic [DATA_WIDTH-1:0] val_r, val_nxt;
  logic [DATA_WIDTH-1:0] anc_r, anc_nxt;
  logic [PW-1:0]         head_r, head_nxt, tail_r, tail_nxt;
  logic [PW-1:0]         fhead_r, fhead_nxt, ftail_r, ftail_nxt;
  logic [PW-1:0]         count_r, count_nxt;
  logic [PW-1:0]         cur_r, cur_nxt;
  logic [PW-1:0]         n_r, n_nxt;
  logic [PW-1:0]         nx_r, nx_nxt;
  status_t               status_r, status_nxt;
  logic [PW-1:0]         idx_r, idx_nxt;
  logic                  out_valid_r, out_valid_nxt;
  status_t               out_status_r, out_status_nxt;
  logic [7:0]            out_idx_r, out_idx_nxt;
  logic [8:0]            out_count_r, out_count_nxt;

  logic                  d_we, n_we, p_we;
  logic [IW-1:0]         d_waddr, n_waddr, p_waddr;
  logic [IW-1:0]         d_raddr, n_raddr, p_raddr;
  logic [DATA_WIDTH-1:0] d_wdata, d_rdata;
  logic [PW-1:0]         n_wdata, n_rdata, p_wdata, p_rdata;
  logic [DATA_WIDTH-1:0] key;
  logic                  hit;
  logic                  accept;

  llfp_ram #(.WIDTH(DATA_WIDTH), .DEPTH(NODES)) u_data (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
    .raddr(d_raddr), .rdata(d_rdata)
  );

  llfp_ram #(.WIDTH(PW), .DEPTH(NODES)) u_next (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
    .raddr(n_raddr), .rdata(n_rdata)
  );

  llfp_ram #(.WIDTH(PW), .DEPTH(NODES)) u_prev (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  assign in_stall       = (state_r != S_IDLE);
  assign accept         = in_valid && !in_stall;
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_node_index = out_idx_r;
  assign out_used_count = out_count_r;

  // The one comparator of the walk: insert searches for the anchor, the others for the value.
  assign key = (kind_r == KIND_INSERT) ? anc_r : val_r;
  assign hit = (d_rdata == key);

  always_comb begin
    state_nxt      = state_r;
    init_nxt       = init_r;
    clr_nxt        = clr_r;
    kind_nxt       = kind_r;
    val_nxt        = val_r;
    anc_nxt        = anc_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    fhead_nxt      = fhead_r;
    ftail_nxt      = ftail_r;
    count_nxt      = count_r;
    cur_nxt        = cur_r;
    n_nxt          = n_r;
    nx_nxt         = nx_r;
    status_nxt     = status_r;
    idx_nxt        = idx_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_idx_nxt    = out_idx_r;
    out_count_nxt  = out_count_r;

    d_we    = 1'b0;
    d_waddr = n_r[IW-1:0];
    d_wdata = val_r;
    d_raddr = cur_r[IW-1:0];
    n_we    = 1'b0;
    n_waddr = n_r[IW-1:0];
    n_wdata = NIL;
    n_raddr = cur_r[IW-1:0];
    p_we    = 1'b0;
    p_waddr = n_r[IW-1:0];
    p_wdata = NIL;
    p_raddr = cur_r[IW-1:0];

    unique case (state_r)
      S_CLR: begin
        // Rebuild the free chain in index order, one node per cycle.
        n_we    = 1'b1;
        n_waddr = clr_r;
        n_wdata = {1'b0, clr_r} + PW'(1);
        p_we    = 1'b1;
        p_waddr = clr_r;
        p_wdata = (clr_r == '0) ? NIL : ({1'b0, clr_r} - PW'(1));
        if (clr_r == LAST_IDX) begin
          head_nxt   = NIL;
          tail_nxt   = NIL;
          fhead_nxt  = '0;
          ftail_nxt  = {1'b0, LAST_IDX};
          count_nxt  = '0;
          status_nxt = ST_DONE;
          idx_nxt    = '0;
          init_nxt   = 1'b0;
          state_nxt  = init_r ? S_IDLE : S_DONE;
        end else begin
          clr_nxt = clr_r + IW'(1);
        end
      end

      S_IDLE: begin
        if (accept) begin
          kind_nxt  = in_kind;
          val_nxt   = DATA_WIDTH'(in_value);
          anc_nxt   = DATA_WIDTH'(in_anchor);
          state_nxt = S_DISP;
        end
      end

      S_DISP: begin
        idx_nxt    = '0;
        status_nxt = ST_DONE;
        unique case (kind_r)
          KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
            if (fhead_r == NIL) begin
              status_nxt = ST_FULL;
              state_nxt  = S_DONE;
            end else begin
              n_nxt     = fhead_r;
              n_raddr   = fhead_r[IW-1:0];
              state_nxt = S_TAKE;
            end
          end
          KIND_INSERT, KIND_DELETE, KIND_FIND: begin
            if (head_r == NIL) begin
              status_nxt = ST_MISS;
              state_nxt  = S_DONE;
            end else begin
              cur_nxt   = head_r;
              d_raddr   = head_r[IW-1:0];
              n_raddr   = head_r[IW-1:0];
              state_nxt = S_WALK;
            end
          end
          KIND_CLEAR: begin
            clr_nxt   = '0;
            state_nxt = S_CLR;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end

      S_WALK: begin
        // Read data belongs to cur_r; on a miss the next link is issued at once.
        if (hit) begin
          nx_nxt = n_rdata;
          priority case (kind_r)
            KIND_FIND: begin
              idx_nxt   = cur_r;
              state_nxt = S_DONE;
            end
            KIND_DELETE: begin
              p_raddr   = cur_r[IW-1:0];
              state_nxt = S_DEL;
            end
            default: begin
              if (fhead_r == NIL) begin
                status_nxt = ST_FULL;
                state_nxt  = S_DONE;
              end else begin
                n_nxt     = fhead_r;
                n_raddr   = fhead_r[IW-1:0];
                state_nxt = S_TAKE;
              end
            end
          endcase
        end else if (n_rdata == NIL) begin
          status_nxt = ST_MISS;
          state_nxt  = S_DONE;
        end else begin
          cur_nxt = n_rdata;
          d_raddr = n_rdata[IW-1:0];
          n_raddr = n_rdata[IW-1:0];
        end
      end

      S_TAKE: begin
        // n_rdata is the successor of the taken node on the free chain.
        fhead_nxt = n_rdata;
        d_we      = 1'b1;
        if (n_rdata != NIL) begin
          p_we    = 1'b1;
          p_waddr = n_rdata[IW-1:0];
          p_wdata = NIL;
        end else begin
          ftail_nxt = NIL;
        end
        state_nxt = S_LINK1;
      end

      S_LINK1: begin
        n_we = 1'b1;
        p_we = 1'b1;
        priority case (kind_r)
          KIND_PUSH_BACK: begin
            p_wdata = tail_r;
            n_wdata = NIL;
          end
          KIND_PUSH_FRONT: begin
            p_wdata = NIL;
            n_wdata = head_r;
          end
          default: begin
            p_wdata = cur_r;
            n_wdata = nx_r;
          end
        endcase
        state_nxt = S_LINK2;
      end

      S_LINK2: begin
        priority case (kind_r)
          KIND_PUSH_BACK: begin
            if (tail_r != NIL) begin
              n_we    = 1'b1;
              n_waddr = tail_r[IW-1:0];
              n_wdata = n_r;
            end else begin
              head_nxt = n_r;
            end
            tail_nxt = n_r;
          end
          KIND_PUSH_FRONT: begin
            if (head_r != NIL) begin
              p_we    = 1'b1;
              p_waddr = head_r[IW-1:0];
              p_wdata = n_r;
            end else begin
              tail_nxt = n_r;
            end
            head_nxt = n_r;
          end
          default: begin
            n_we    = 1'b1;
            n_waddr = cur_r[IW-1:0];
            n_wdata = n_r;
            if (nx_r != NIL) begin
              p_we    = 1'b1;
              p_waddr = nx_r[IW-1:0];
              p_wdata = n_r;
            end else begin
              tail_nxt = n_r;
            end
          end
        endcase
        count_nxt = count_r + PW'(1);
        idx_nxt   = n_r;
        state_nxt = S_DONE;
      end

      S_DEL: begin
        // p_rdata is the predecessor of the node being removed.
        if (p_rdata != NIL) begin
          n_we    = 1'b1;
          n_waddr = p_rdata[IW-1:0];
          n_wdata = nx_r;
        end else begin
          head_nxt = nx_r;
        end
        if (nx_r != NIL) begin
          p_we    = 1'b1;
          p_waddr = nx_r[IW-1:0];
          p_wdata = p_rdata;
        end else begin
          tail_nxt = p_rdata;
        end
        state_nxt = S_FREE;
      end

      S_FREE: begin
        p_we      = 1'b1;
        p_waddr   = cur_r[IW-1:0];
        p_wdata   = ftail_r;
        n_we      = 1'b1;
        n_waddr   = cur_r[IW-1:0];
        n_wdata   = NIL;
        state_nxt = S_FREE2;
      end

      S_FREE2: begin
        if (ftail_r != NIL) begin
          n_we    = 1'b1;
          n_waddr = ftail_r[IW-1:0];
          n_wdata = cur_r;
        end else begin
          fhead_nxt = cur_r;
        end
        ftail_nxt = cur_r;
        if (count_r != '0) begin
          count_nxt = count_r - PW'(1);
        end
        idx_nxt   = cur_r;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_idx_nxt    = IDX_OUT_W'(idx_r);
          out_count_nxt  = COUNT_OUT_W'(count_r);
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      init_r      <= 1'b1;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      head_r      <= NIL;
      tail_r      <= NIL;
      fhead_r     <= '0;
      ftail_r     <= {1'b0, LAST_IDX};
      count_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      init_r      <= init_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      fhead_r     <= fhead_nxt;
      ftail_r     <= ftail_nxt;
      count_r     <= count_nxt;
    end
    kind_r       <= kind_nxt;
    val_r        <= val_nxt;
    anc_r        <= anc_nxt;
    cur_r        <= cur_nxt;
    n_r          <= n_nxt;
    nx_r         <= nx_nxt;
    status_r     <= status_nxt;
    idx_r        <= idx_nxt;
    out_status_r <= out_status_nxt;
    out_idx_r    <= out_idx_nxt;
    out_count_r  <= out_count_nxt;
  end

endmodule

### rtl/llfp_chk.sv
// Port-level checker for the linked list with free pool, bound to the top level.
// Depends on llfp_pkg for the status codes.
module llfp_chk
  import llfp_pkg::*;
#(
  parameter int NODES = 256
) (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic [1:0] out_status,
  input logic [7:0] out_node_index,
  input logic [8:0] out_used_count
);

  // A failed operation names no node.
  a_idx_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_DONE) |-> (out_node_index == '0))
    else $error("node index not zero on a failed operation");

  // The pool is only reported full when every node is on the list.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL) |-> (out_used_count == 9'(NODES)))
    else $error("pool full reported with free nodes left");

  // An accepted beat keeps the block busy for at least the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted twice in consecutive cycles");

  // Reset empties the result register.
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat present after reset");

endmodule

bind linked_list_with_free_pool_unit llfp_chk #(.NODES(NODES)) u_llfp_chk (.*);

### test/tb_linked_list_with_free_pool_unit.sv
// Testbench for linked_list_with_free_pool_unit: directed table, then random list operations.
// Each beat is checked against a shadow model kept here, or a directed row's typed result.
// Depends on llfp_pkg and the RTL of the unit; reads no files.
module tb_linked_list_with_free_pool_unit
  import llfp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int POOL = 256;
  localparam logic [8:0] NIL = 9'd256;
  localparam kind_t KIND_UNUSED_A = 3'd6;
  localparam kind_t KIND_UNUSED_B = 3'd7;
  localparam int N_RANDOM = 1975;
  localparam int IDLE_PCT = 21;

  typedef struct packed {
    status_t                  status;
    logic [IDX_OUT_W-1:0]     idx;
    logic [COUNT_OUT_W-1:0]   count;
  } result_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] value;
    logic [31:0] anchor;
    bit          typed;
    result_t     res;
  } op_row_t;

  localparam result_t NO_RES = '0;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_kind = '0;
  logic [31:0] in_value = '0;
  logic [31:0] in_anchor = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [7:0]  out_node_index;
  logic [8:0]  out_used_count;

  // Shadow of the node pool and both chains.
  logic [31:0] pool_data [POOL];
  logic [8:0]  pool_next [POOL];
  logic [8:0]  pool_prev [POOL];
  logic [8:0]  list_head, list_tail, free_head, free_tail, list_len;

  result_t expected_results [$];
  result_t want;
  bit      quiet = 1'b0;
  int      n_errors = 0;
  int      n_sent = 0;
  int      n_checked = 0;
  int      n_full = 0;
  int      n_miss = 0;

  // Directed rows; typed expectations only where they follow straight from reset or clear.
  op_row_t dir_rows [25] = '{
    '{KIND_FIND,       32'h0000_0000, 32'h0,          1'b1, '{ST_MISS, 8'd0, 9'd0}},
    '{KIND_DELETE,     32'h0000_0005, 32'h0,          1'b1, '{ST_MISS, 8'd0, 9'd0}},
    '{KIND_INSERT,     32'h0000_0009, 32'h0000_0001,  1'b1, '{ST_MISS, 8'd0, 9'd0}},
    '{KIND_PUSH_BACK,  32'hFFFF_FFFF, 32'hFFFF_FFFF,  1'b1, '{ST_DONE, 8'd0, 9'd1}},
    '{KIND_PUSH_FRONT, 32'h0000_0000, 32'h0,          1'b1, '{ST_DONE, 8'd1, 9'd2}},
    '{KIND_PUSH_BACK,  32'h8000_0001, 32'h0,          1'b1, '{ST_DONE, 8'd2, 9'd3}},
    '{KIND_INSERT,     32'h7FFF_FFFE, 32'hFFFF_FFFF,  1'b0, NO_RES},
    '{KIND_PUSH_BACK,  32'hFFFF_FFFF, 32'h0,          1'b0, NO_RES},
    '{KIND_FIND,       32'hFFFF_FFFF, 32'h0,          1'b0, NO_RES},
    '{KIND_DELETE,     32'hFFFF_FFFF, 32'h0,          1'b0, NO_RES},
    '{KIND_FIND,       32'hFFFF_FFFF, 32'h0,          1'b0, NO_RES},
    '{KIND_UNUSED_A,   32'hFFFF_FFFF, 32'hFFFF_FFFF,  1'b0, NO_RES},
    '{KIND_INSERT,     32'h0000_0042, 32'h0000_1234,  1'b0, NO_RES},
    '{KIND_DELETE,     32'h0000_0000, 32'h0,          1'b0, NO_RES},
    '{KIND_DELETE,     32'hFFFF_FFFF, 32'h0,          1'b0, NO_RES},
    '{KIND_INSERT,     32'h0F0F_F0F0, 32'h8000_0001,  1'b0, NO_RES},
    '{KIND_PUSH_FRONT, 32'h5555_5555, 32'hAAAA_AAAA,  1'b0, NO_RES},
    '{KIND_CLEAR,      32'hFFFF_FFFF, 32'hFFFF_FFFF,  1'b1, '{ST_DONE, 8'd0, 9'd0}},
    '{KIND_FIND,       32'h0000_0000, 32'h0,          1'b1, '{ST_MISS, 8'd0, 9'd0}},
    '{KIND_PUSH_BACK,  32'hAAAA_AAAA, 32'h0,          1'b1, '{ST_DONE, 8'd0, 9'd1}},
    '{KIND_PUSH_FRONT, 32'h0000_0001, 32'h0,          1'b1, '{ST_DONE, 8'd1, 9'd2}},
    '{KIND_DELETE,     32'hAAAA_AAAA, 32'h0,          1'b0, NO_RES},
    '{KIND_PUSH_BACK,  32'h1234_5678, 32'h0,          1'b0, NO_RES},
    '{KIND_DELETE,     32'h0000_0001, 32'h0,          1'b0, NO_RES},
    '{KIND_DELETE,     32'h1234_5678, 32'h0,          1'b0, NO_RES}
  };

  linked_list_with_free_pool_unit u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_value       (in_value),
    .in_anchor      (in_anchor),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_node_index (out_node_index),
    .out_used_count (out_used_count)
  );

  always #1 clk = ~clk;

  function automatic void pool_reset();
    for (int i = 0; i < POOL; i++) begin
      pool_next[i] = (i + 1 < POOL) ? 9'(i + 1) : NIL;
      pool_prev[i] = (i > 0) ? 9'(i - 1) : NIL;
    end
    list_head = NIL;
    list_tail = NIL;
    free_head = 9'd0;
    free_tail = 9'(POOL - 1);
    list_len  = 9'd0;
  endfunction

  function automatic logic [8:0] take_node();
    logic [8:0] n;
    n = free_head;
    if (n == NIL) return NIL;
    free_head = pool_next[n[7:0]];
    if (free_head != NIL) pool_prev[free_head[7:0]] = NIL;
    else free_tail = NIL;
    return n;
  endfunction

  function automatic void return_node(logic [8:0] n);
    pool_prev[n[7:0]] = free_tail;
    pool_next[n[7:0]] = NIL;
    if (free_tail != NIL) pool_next[free_tail[7:0]] = n;
    else free_head = n;
    free_tail = n;
  endfunction

  function automatic logic [8:0] first_holding(logic [31:0] v);
    logic [8:0] n;
    int steps;
    n = list_head;
    steps = 0;
    while (n != NIL && steps < POOL) begin
      if (pool_data[n[7:0]] == v) return n;
      n = pool_next[n[7:0]];
      steps++;
    end
    return NIL;
  endfunction

  // Applies one operation to the shadow pool and returns the beat it should produce.
  function automatic result_t list_op(kind_t k, logic [31:0] v, logic [31:0] a);
    result_t r;
    logic [8:0] n, at, nx, pv;
    r = '0;
    case (k)
      KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
        n = take_node();
        if (n == NIL) begin
          r.status = ST_FULL;
        end else begin
          pool_data[n[7:0]] = v;
          if (k == KIND_PUSH_BACK) begin
            pool_prev[n[7:0]] = list_tail;
            pool_next[n[7:0]] = NIL;
            if (list_tail != NIL) pool_next[list_tail[7:0]] = n;
            else list_head = n;
            list_tail = n;
          end else begin
            pool_prev[n[7:0]] = NIL;
            pool_next[n[7:0]] = list_head;
            if (list_head != NIL) pool_prev[list_head[7:0]] = n;
            else list_tail = n;
            list_head = n;
          end
          list_len++;
          r.idx = n[7:0];
        end
      end
      KIND_INSERT: begin
        at = first_holding(a);
        if (at == NIL) begin
          r.status = ST_MISS;
        end else begin
          n = take_node();
          if (n == NIL) begin
            r.status = ST_FULL;
          end else begin
            pool_data[n[7:0]] = v;
            nx = pool_next[at[7:0]];
            pool_prev[n[7:0]] = at;
            pool_next[n[7:0]] = nx;
            pool_next[at[7:0]] = n;
            if (nx != NIL) pool_prev[nx[7:0]] = n;
            else list_tail = n;
            list_len++;
            r.idx = n[7:0];
          end
        end
      end
      KIND_DELETE: begin
        n = first_holding(v);
        if (n == NIL) begin
          r.status = ST_MISS;
        end else begin
          nx = pool_next[n[7:0]];
          pv = pool_prev[n[7:0]];
          if (pv != NIL) pool_next[pv[7:0]] = nx;
          else list_head = nx;
          if (nx != NIL) pool_prev[nx[7:0]] = pv;
          else list_tail = pv;
          return_node(n);
          if (list_len != 0) list_len--;
          r.idx = n[7:0];
        end
      end
      KIND_FIND: begin
        n = first_holding(v);
        if (n == NIL) r.status = ST_MISS;
        else r.idx = n[7:0];
      end
      KIND_CLEAR: pool_reset();
      default: ;
    endcase
    r.count = list_len;
    return r;
  endfunction

  function automatic logic [31:0] random_word();
    case ($urandom_range(9))
      0, 1: return 32'($urandom_range(7));
      2: begin
        case ($urandom_range(3))
          0: return 32'h0000_0000;
          1: return 32'hFFFF_FFFF;
          2: return 32'h8000_0000;
          default: return 32'h7FFF_FFFF;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // Value held by a randomly chosen node on the list, so that searches mostly hit.
  function automatic logic [31:0] listed_word();
    logic [8:0] n;
    int hops;
    if (list_len == 0) return random_word();
    hops = $urandom_range(list_len - 1);
    n = list_head;
    repeat (hops) n = pool_next[n[7:0]];
    return pool_data[n[7:0]];
  endfunction

  task automatic pick_op(input bit filling, output kind_t k, output logic [31:0] v,
                         output logic [31:0] a);
    int r;
    r = $urandom_range(99);
    v = random_word();
    a = $urandom;
    if (filling) begin
      if (r < 35) k = KIND_PUSH_BACK;
      else if (r < 55) k = KIND_PUSH_FRONT;
      else if (r < 85) k = KIND_INSERT;
      else if (r < 92) k = KIND_DELETE;
      else k = KIND_FIND;
    end else begin
      if (r < 18) k = KIND_PUSH_BACK;
      else if (r < 33) k = KIND_PUSH_FRONT;
      else if (r < 48) k = KIND_INSERT;
      else if (r < 68) k = KIND_DELETE;
      else if (r < 88) k = KIND_FIND;
      else if (r < 94) k = $urandom_range(1) ? KIND_UNUSED_A : KIND_UNUSED_B;
      else if (r < 99) k = KIND_PUSH_BACK;
      else k = KIND_CLEAR;
      // Keep the list short outside the fill phase so that walks stay cheap.
      if (list_len > 48 && (k == KIND_PUSH_BACK || k == KIND_PUSH_FRONT || k == KIND_INSERT))
        k = KIND_DELETE;
    end
    if (k == KIND_INSERT && $urandom_range(9) < 8) a = listed_word();
    if ((k == KIND_DELETE || k == KIND_FIND) && $urandom_range(3) != 0) v = listed_word();
  endtask

  // Presents one beat, holds it until taken and records what it should produce.
  task automatic send_op(input kind_t k, input logic [31:0] v, input logic [31:0] a,
                         input bit typed, input result_t typed_res);
    result_t predicted;
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_kind   <= k;
    in_value  <= v;
    in_anchor <= a;
    do @(posedge clk); while (in_stall);
    predicted = list_op(k, v, a);
    expected_results.push_back(typed ? typed_res : predicted);
    n_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected: status %0d node_index %0d used_count %0d",
               out_status, out_node_index, out_used_count);
        n_errors++;
      end else begin
        want = expected_results.pop_front();
        n_checked++;
        if (want.status == ST_FULL) n_full++;
        if (want.status == ST_MISS) n_miss++;
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          n_errors++;
        end
        if (out_node_index !== want.idx) begin
          $error("node_index: expected %0d, got %0d", want.idx, out_node_index);
          n_errors++;
        end
        if (out_used_count !== want.count) begin
          $error("used_count: expected %0d, got %0d", want.count, out_used_count);
          n_errors++;
        end
      end
    end
  end

  initial begin
    kind_t       k;
    logic [31:0] v, a;
    pool_reset();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      send_op(dir_rows[i].kind, dir_rows[i].value, dir_rows[i].anchor,
              dir_rows[i].typed, dir_rows[i].res);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 650) begin
        // Let everything drain before the fill phase starts from a cleared pool.
        drain();
        send_op(KIND_CLEAR, $urandom, $urandom, 1'b0, NO_RES);
      end else if (i == 1100) begin
        send_op(KIND_CLEAR, $urandom, $urandom, 1'b0, NO_RES);
      end else begin
        quiet = (i >= 1200 && i < 1500);
        pick_op(i > 650 && i < 1100, k, v, a);
        send_op(k, v, a, 1'b0, NO_RES);
      end
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (POOL + 40) @(posedge clk);

    $display("Sent %0d operations and checked %0d result beats,", n_sent, n_checked);
    $display("of which %0d found the pool full and %0d missed their value.", n_full, n_miss);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
